FILE: rtl/phr_pkg.sv
// shared types, constants and hash step for the path hash rule check block
package phr_pkg;

    localparam int RULE_ENTRIES   = 16;
    localparam int MAX_PATH_BYTES = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam int HASH_W   = 64;
    localparam int MASK_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int RCOUNT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int IDX_W  = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(RULE_ENTRIES + 1);
    localparam int BCNT_W = $clog2(MAX_PATH_BYTES + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = HASH_W + MASK_W;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [MASK_W-1:0] NEED_WRITE = 8'h02;
    localparam logic [MASK_W-1:0] NEED_READ  = 8'h04;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENFORCING  = 2'd0,
        CFG_RULE_COUNT = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        DEC_ALLOW_AUDIT  = 2'd0,
        DEC_DENY         = 2'd1,
        DEC_ALLOW_SILENT = 2'd2,
        DEC_PRIOR_FAIL   = 2'd3
    } decision_t;

    // request handed from the front to the back
    typedef struct packed {
        logic              is_rule;
        logic [HASH_W-1:0] hash;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] access;
        logic              write_access;
        logic              path_unresolved;
        logic              prior_failed;
    } phr_item_t;

    // xor byte, multiply by 0x100000001b3 as shift-add
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

FILE: rtl/phr_if.sv
// request channel interfaces: input items, results and configuration writes
interface phr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [7:0]                  path_byte;
    logic                        last_byte;
    logic                        write_access;
    logic                        path_unresolved;
    logic                        prior_failed;
    logic [phr_pkg::SLOT_W-1:0]  rule_slot;
    logic [phr_pkg::HASH_W-1:0]  rule_hash;
    logic [phr_pkg::MASK_W-1:0]  rule_access;

    modport source (
        output valid, operation, path_byte, last_byte, write_access,
               path_unresolved, prior_failed, rule_slot, rule_hash, rule_access,
        input  ready
    );
    modport sink (
        input  valid, operation, path_byte, last_byte, write_access,
               path_unresolved, prior_failed, rule_slot, rule_hash, rule_access,
        output ready
    );
endinterface

interface phr_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  decision;
    logic [phr_pkg::HASH_W-1:0]  final_hash;
    logic                        match_found;
    logic [phr_pkg::SLOT_W-1:0]  matched_slot;

    modport source (
        output valid, decision, final_hash, match_found, matched_slot,
        input  ready
    );
    modport sink (
        input  valid, decision, final_hash, match_found, matched_slot,
        output ready
    );
endinterface

interface phr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [phr_pkg::CFG_IDX_W-1:0]  index;
    logic [phr_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/phr_ram.sv
// generic single-write, registered-read ram
module phr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/phr_front.sv
// front: accepts items, folds path bytes into the fnv-1a hash, queues rule writes and decisions
module phr_front (
    input  logic                clk,
    input  logic                rst_n,
    phr_in_if.sink              in_ch,
    input  logic                q_full,
    output logic                q_push,
    output phr_pkg::phr_item_t  q_item
);
    import phr_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [BCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              counting;
    logic [HASH_W-1:0] new_hash;

    always_comb
    begin
        in_ch.ready = !q_full;
        accept      = in_ch.valid && !q_full;
        counting    = count_reg < BCNT_W'(MAX_PATH_BYTES);
        new_hash    = counting ? fnv_step(hash_reg, in_ch.path_byte) : hash_reg;

        hash_next  = hash_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            if (in_ch.operation)
            begin
                q_push = 1'b1;
            end
            else if (in_ch.last_byte)
            begin
                q_push     = 1'b1;
                hash_next  = FNV_BASIS;
                count_next = '0;
            end
            else
            begin
                hash_next = new_hash;
                if (counting)
                begin
                    count_next = count_reg + BCNT_W'(1);
                end
            end
        end

        q_item.is_rule         = in_ch.operation;
        q_item.hash            = in_ch.operation ? in_ch.rule_hash : new_hash;
        q_item.slot            = in_ch.rule_slot;
        q_item.access          = in_ch.rule_access;
        q_item.write_access    = in_ch.write_access;
        q_item.path_unresolved = in_ch.path_unresolved;
        q_item.prior_failed    = in_ch.prior_failed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= FNV_BASIS;
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
        end
    end
endmodule

FILE: rtl/phr_queue.sv
// short fifo of requests between front and back
module phr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  phr_pkg::phr_item_t  push_item,
    input  logic                pop,
    output phr_pkg::phr_item_t  head_item,
    output logic                full,
    output logic                empty
);
    import phr_pkg::*;

    phr_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        full      = count_reg == QCNT_W'(QUEUE_DEPTH);
        empty     = count_reg == '0;
        head_item = entry_reg[rd_ptr_reg];

        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

FILE: rtl/phr_back.sv
// back: holds config, writes the rule table and scans it for each enforced decision that needs a rule lookup
module phr_back (
    input  logic                clk,
    input  logic                rst_n,
    phr_cfg_if.sink             cfg_ch,
    input  logic                q_empty,
    input  phr_pkg::phr_item_t  head_item,
    output logic                q_pop,
    phr_out_if.source           out_ch
);
    import phr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    localparam int CMP_W = (CNT_W > RCOUNT_W) ? CNT_W : RCOUNT_W;

    state_t              state_reg, state_next;
    logic                enforcing_reg, enforcing_next;
    logic [RCOUNT_W-1:0] rule_count_reg, rule_count_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic                wr_reg, wr_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    decision_t           dec_reg, dec_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]    next_idx;
    logic [CNT_W-1:0]    clamp_limit;
    logic [MASK_W-1:0]   need;
    logic                hit;

    phr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RULE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({head_item.hash, head_item.access}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cfg_ch.ready    = 1'b1;
        enforcing_next  = enforcing_reg;
        rule_count_next = rule_count_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_ENFORCING:  enforcing_next  = cfg_ch.data[0];
                CFG_RULE_COUNT: rule_count_next = cfg_ch.data[RCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        clamp_limit = (CMP_W'(rule_count_reg) > CMP_W'(RULE_ENTRIES))
                      ? CNT_W'(RULE_ENTRIES) : CNT_W'(rule_count_reg);
        next_idx  = CNT_W'(idx_reg) + CNT_W'(1);
        ram_raddr = (state_reg == ST_SCAN) ? IDX_W'(next_idx) : '0;
        ram_waddr = IDX_W'(head_item.slot);
        need      = wr_reg ? NEED_WRITE : NEED_READ;
        hit       = ram_rdata[ENTRY_W-1:MASK_W] == hash_reg;

        state_next = state_reg;
        hash_next  = hash_reg;
        wr_next    = wr_reg;
        limit_next = limit_reg;
        idx_next   = idx_reg;
        dec_next   = dec_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head_item.is_rule)
                    begin
                        ram_we = 32'(head_item.slot) < RULE_ENTRIES;
                    end
                    else
                    begin
                        hash_next  = head_item.hash;
                        wr_next    = head_item.write_access;
                        limit_next = clamp_limit;
                        idx_next   = '0;
                        found_next = 1'b0;
                        slot_next  = '0;
                        dec_next   = DEC_ALLOW_AUDIT;
                        state_next = ST_OUT;
                        if (head_item.prior_failed)
                        begin
                            dec_next = DEC_PRIOR_FAIL;
                        end
                        else if (!enforcing_reg || head_item.path_unresolved)
                        begin
                            dec_next = DEC_ALLOW_SILENT;
                        end
                        else if (clamp_limit != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = SLOT_W'(idx_reg);
                    dec_next   = ((ram_rdata[MASK_W-1:0] & need) != need)
                                 ? DEC_DENY : DEC_ALLOW_AUDIT;
                    state_next = ST_OUT;
                end
                else if (next_idx >= limit_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = IDX_W'(next_idx);
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_ch.valid        = state_reg == ST_OUT;
        out_ch.decision     = dec_reg;
        out_ch.final_hash   = hash_reg;
        out_ch.match_found  = found_reg;
        out_ch.matched_slot = slot_reg;
    end

    always_ff @(posedge clk)
    begin
        hash_reg  <= hash_next;
        wr_reg    <= wr_next;
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        dec_reg   <= dec_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enforcing_reg  <= 1'b0;
            rule_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            enforcing_reg  <= enforcing_next;
            rule_count_reg <= rule_count_next;
        end
    end
endmodule

FILE: rtl/path_hash_rule_check_unit.sv
// top level of the path hash rule check block
//
//   channel  dir  request
//   in_ch    in   path byte or rule write
//   out_ch   out  decision with path hash and matched slot
//   cfg_ch   in   register write (0 enforcing, 1 rule_count)
//
// path bytes are taken one per cycle while the queue is not full; the 64-bit hash step is one shift-add per byte.
// the back end pops a rule write and writes it into the table; it pops a decision, scans the slots it
// needs up to min(rule_count, 16), stopping at the first match, then holds the result until out_ch.ready.
// a four-entry queue lets the front keep taking bytes while the back scans or stalls.
// reset clears control and config only; rule table contents are undefined until written.
module path_hash_rule_check_unit (
    input  logic       clk,
    input  logic       rst_n,
    phr_in_if.sink     in_ch,
    phr_out_if.source  out_ch,
    phr_cfg_if.sink    cfg_ch
);
    import phr_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    phr_item_t q_in_item;
    phr_item_t q_head_item;

    phr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in_item)
    );

    phr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    phr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_ch    (cfg_ch),
        .q_empty   (q_empty),
        .head_item (q_head_item),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("request queue underflow");

    a_deny_has_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.decision == DEC_DENY) |-> out_ch.match_found)
        else $error("deny without matching slot");

    a_no_match_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.match_found) |-> (out_ch.matched_slot == '0))
        else $error("slot reported without match");
`endif
endmodule

FILE: verif/testbench.sv
// testbench for path_hash_rule_check_unit: directed and random requests checked by a built-in predictor
`timescale 1ns / 1ps

module testbench;
    import phr_pkg::*;

    localparam logic [HASH_W-1:0]    HASH_PRIME     = 64'h0000_0100_0000_01b3;
    localparam logic                 OP_PATH_BYTE   = 1'b0;
    localparam logic                 OP_RULE_WRITE  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 2'd3;
    localparam int                   POOL_SIZE      = 8;
    localparam int                   LONG_ENTRY     = POOL_SIZE - 1;
    localparam int                   SETTLE_CYCLES  = 100;
    localparam int                   CYCLE_LIMIT    = 200000;
    localparam int                   PHASE_REQUESTS = 56;

    typedef logic [7:0] path_bytes_t[$];

    typedef struct {
        logic              operation;
        logic [7:0]        path_byte;
        logic              last_byte;
        logic              write_access;
        logic              path_unresolved;
        logic              prior_failed;
        logic [SLOT_W-1:0] rule_slot;
        logic [HASH_W-1:0] rule_hash;
        logic [MASK_W-1:0] rule_access;
    } access_req_t;

    typedef struct {
        decision_t         decision;
        logic [HASH_W-1:0] final_hash;
        logic              match_found;
        logic [SLOT_W-1:0] matched_slot;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    phr_in_if  in_ch();
    phr_out_if out_ch();
    phr_cfg_if cfg_ch();

    path_hash_rule_check_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    logic                model_enforcing;
    logic [RCOUNT_W-1:0] model_rule_count;
    logic [HASH_W-1:0]   model_hash;
    int unsigned         model_len;
    logic [HASH_W-1:0]   model_rule_hash [RULE_ENTRIES];
    logic [MASK_W-1:0]   model_rule_mask [RULE_ENTRIES];
    verdict_t            pending_verdicts[$];

    path_bytes_t       path_pool [POOL_SIZE];
    logic [HASH_W-1:0] pool_digest [POOL_SIZE];

    int error_count    = 0;
    int requests_sent  = 0;
    int match_tally    = 0;
    int verdict_tally [4];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        return (h ^ {56'd0, b}) * HASH_PRIME;
    endfunction

    function automatic logic [HASH_W-1:0] path_digest(input path_bytes_t p);
        logic [HASH_W-1:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < p.size() && i < MAX_PATH_BYTES; i++)
            h = fold_byte(h, p[i]);
        return h;
    endfunction

    function automatic path_bytes_t random_path(input int min_len, input int max_len);
        path_bytes_t p;
        int n;
        n = $urandom_range(max_len, min_len);
        repeat (n) p.push_back(8'($urandom));
        return p;
    endfunction

    function automatic access_req_t noise_request();
        access_req_t r;
        r.operation       = 1'($urandom);
        r.path_byte       = 8'($urandom);
        r.last_byte       = 1'($urandom);
        r.write_access    = 1'($urandom);
        r.path_unresolved = 1'($urandom);
        r.prior_failed    = 1'($urandom);
        r.rule_slot       = SLOT_W'($urandom);
        r.rule_hash       = {$urandom, $urandom};
        r.rule_access     = MASK_W'($urandom);
        return r;
    endfunction

    function automatic access_req_t rule_write(input logic [SLOT_W-1:0] slot,
                                               input logic [HASH_W-1:0] h,
                                               input logic [MASK_W-1:0] m);
        access_req_t r;
        r             = noise_request();
        r.operation   = OP_RULE_WRITE;
        r.rule_slot   = slot;
        r.rule_hash   = h;
        r.rule_access = m;
        return r;
    endfunction

    function automatic access_req_t random_rule_write();
        logic [HASH_W-1:0] h;
        logic [MASK_W-1:0] m;
        if ($urandom_range(9) < 6)
            h = pool_digest[$urandom_range(POOL_SIZE - 1)];
        else
            h = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       m = NEED_WRITE;
            1:       m = NEED_READ;
            2:       m = NEED_WRITE | NEED_READ;
            default: m = MASK_W'($urandom);
        endcase
        return rule_write(SLOT_W'($urandom), h, m);
    endfunction

    task automatic predict_request(input access_req_t r);
        verdict_t          v;
        logic [MASK_W-1:0] need;
        int                scan_len;
        if (r.operation == OP_RULE_WRITE)
        begin
            model_rule_hash[r.rule_slot] = r.rule_hash;
            model_rule_mask[r.rule_slot] = r.rule_access;
            return;
        end
        if (model_len < MAX_PATH_BYTES)
        begin
            model_hash = fold_byte(model_hash, r.path_byte);
            model_len++;
        end
        if (!r.last_byte)
            return;
        v.final_hash   = model_hash;
        v.match_found  = 1'b0;
        v.matched_slot = '0;
        if (r.prior_failed)
            v.decision = DEC_PRIOR_FAIL;
        else if (!model_enforcing || r.path_unresolved)
            v.decision = DEC_ALLOW_SILENT;
        else
        begin
            need     = r.write_access ? NEED_WRITE : NEED_READ;
            scan_len = (model_rule_count > RULE_ENTRIES) ? RULE_ENTRIES : model_rule_count;
            v.decision = DEC_ALLOW_AUDIT;
            for (int i = 0; i < scan_len && !v.match_found; i++)
            begin
                if (model_rule_hash[i] == v.final_hash)
                begin
                    v.match_found  = 1'b1;
                    v.matched_slot = SLOT_W'(i);
                    if ((model_rule_mask[i] & need) != need)
                        v.decision = DEC_DENY;
                end
            end
        end
        pending_verdicts.push_back(v);
        model_hash = FNV_BASIS;
        model_len  = 0;
    endtask

    task automatic send_request(input access_req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.operation       <= r.operation;
        in_ch.path_byte       <= r.path_byte;
        in_ch.last_byte       <= r.last_byte;
        in_ch.write_access    <= r.write_access;
        in_ch.path_unresolved <= r.path_unresolved;
        in_ch.prior_failed    <= r.prior_failed;
        in_ch.rule_slot       <= r.rule_slot;
        in_ch.rule_hash       <= r.rule_hash;
        in_ch.rule_access     <= r.rule_access;
        do @(posedge clk); while (!in_ch.ready);
        predict_request(r);
        requests_sent++;
    endtask

    task automatic send_path(input path_bytes_t p, input logic wr, input logic unres,
                             input logic prior, input int rule_mix_pct);
        access_req_t r;
        for (int i = 0; i < p.size(); i++)
        begin
            if ($urandom_range(99) < rule_mix_pct)
                send_request(random_rule_write());
            r           = noise_request();
            r.operation = OP_PATH_BYTE;
            r.path_byte = p[i];
            r.last_byte = (i == p.size() - 1);
            if (r.last_byte)
            begin
                r.write_access    = wr;
                r.path_unresolved = unres;
                r.prior_failed    = prior;
            end
            send_request(r);
        end
    endtask

    task automatic drain_results(input int extra_cycles);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_ENFORCING)
            model_enforcing = data[0];
        else if (idx == CFG_RULE_COUNT)
            model_rule_count = data[RCOUNT_W-1:0];
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic enf, input logic [RCOUNT_W-1:0] count);
        drain_results(SETTLE_CYCLES);
        write_register(CFG_ENFORCING, {7'($urandom), enf});
        write_register(CFG_RULE_COUNT, {3'($urandom), count});
    endtask

    task automatic check_verdict();
        verdict_t v;
        if (pending_verdicts.size() == 0)
        begin
            $error("unexpected result: decision %0d final_hash %h",
                   out_ch.decision, out_ch.final_hash);
            error_count++;
        end
        else
        begin
            v = pending_verdicts.pop_front();
            if (out_ch.decision !== v.decision)
            begin
                $error("decision: expected %0d, actual %0d", v.decision, out_ch.decision);
                error_count++;
            end
            if (out_ch.final_hash !== v.final_hash)
            begin
                $error("final_hash: expected %h, actual %h", v.final_hash, out_ch.final_hash);
                error_count++;
            end
            if (out_ch.match_found !== v.match_found)
            begin
                $error("match_found: expected %0d, actual %0d",
                       v.match_found, out_ch.match_found);
                error_count++;
            end
            if (out_ch.matched_slot !== v.matched_slot)
            begin
                $error("matched_slot: expected %0d, actual %0d",
                       v.matched_slot, out_ch.matched_slot);
                error_count++;
            end
            verdict_tally[v.decision]++;
            if (v.match_found)
                match_tally++;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            check_verdict();
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_table_load();
        logic [HASH_W-1:0] h;
        logic [MASK_W-1:0] m;
        path_pool[0].push_back(8'h00);
        path_pool[1].push_back(8'hff);
        for (int i = 2; i < LONG_ENTRY; i++)
            path_pool[i] = random_path(2, 6);
        path_pool[LONG_ENTRY] = random_path(MAX_PATH_BYTES + 1, MAX_PATH_BYTES + 1);
        for (int i = 0; i < POOL_SIZE; i++)
            pool_digest[i] = path_digest(path_pool[i]);
        // fill every slot before any scan can reach it
        for (int s = 0; s < RULE_ENTRIES; s++)
        begin
            case (s)
                0:       begin h = '0;             m = '0;         end
                1:       begin h = '1;             m = '1;         end
                2:       begin h = pool_digest[0]; m = NEED_READ;  end
                3:       begin h = pool_digest[1]; m = NEED_WRITE; end
                4:       begin h = pool_digest[1]; m = '1;         end
                default:
                begin
                    h = (s < 11) ? pool_digest[s - 3] : {$urandom, $urandom};
                    m = MASK_W'($urandom);
                end
            endcase
            send_request(rule_write(SLOT_W'(s), h, m));
        end
    endtask

    task automatic test_register_map();
        drain_results(SETTLE_CYCLES);
        write_register(CFG_SPARE_LO, 8'($urandom));
        write_register(CFG_SPARE_HI, 8'($urandom));
        apply_setting(1'b1, 5'd16);
    endtask

    task automatic test_decisions();
        send_path(path_pool[0], 1'b0, 1'b0, 1'b0, 0);
        send_path(path_pool[0], 1'b1, 1'b0, 1'b0, 0);
        send_path(path_pool[1], 1'b1, 1'b0, 1'b0, 0);
        send_path(path_pool[1], 1'b0, 1'b0, 1'b0, 0);
        send_path(path_pool[0], 1'b0, 1'b1, 1'b1, 0);
        send_path(path_pool[0], 1'b0, 1'b1, 1'b0, 0);
        send_path(random_path(3, 3), 1'b0, 1'b0, 1'b0, 0);
        apply_setting(1'b1, 5'd2);
        send_path(path_pool[0], 1'b0, 1'b0, 1'b0, 0);
        apply_setting(1'b0, 5'd16);
        send_path(path_pool[1], 1'b1, 1'b0, 1'b0, 0);
        apply_setting(1'b1, 5'd16);
        // rule writes in the middle of a path
        send_path(random_path(2, 2), 1'b1, 1'b0, 1'b0, 100);
    endtask

    task automatic test_overlong_path();
        send_path(path_pool[LONG_ENTRY], 1'b0, 1'b0, 1'b0, 0);
        send_path(random_path(MAX_PATH_BYTES, MAX_PATH_BYTES), 1'b1, 1'b0, 1'b0, 0);
    endtask

    task automatic test_random_traffic();
        int          enf_plan [8]   = '{1, 1, 1, 0, 1, 1, 1, 1};
        int          count_plan [8] = '{16, 31, 0, 16, 1, 17, 8, 16};
        int          send_plan [8]  = '{0, 86, 0, 14, 0, 86, 0, 14};
        int          recv_plan [8]  = '{0, 0, 86, 14, 0, 0, 86, 14};
        int          phase_start;
        bit          held;
        path_bytes_t p;
        for (int ph = 0; ph < 8; ph++)
        begin
            apply_setting(1'(enf_plan[ph]), RCOUNT_W'(count_plan[ph]));
            send_idle_pct  = send_plan[ph];
            recv_stall_pct = recv_plan[ph];
            phase_start    = requests_sent;
            held           = 1'b0;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                if (ph == 0 && !held && requests_sent - phase_start >= PHASE_REQUESTS / 2)
                begin
                    drain_results(0);
                    held = 1'b1;
                end
                if ($urandom_range(99) < 70)
                    p = path_pool[$urandom_range(LONG_ENTRY - 1)];
                else
                    p = random_path(1, 10);
                send_path(p, 1'($urandom), ($urandom_range(9) == 0),
                          ($urandom_range(9) == 0), 8);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.operation       <= OP_PATH_BYTE;
        in_ch.path_byte       <= '0;
        in_ch.last_byte       <= 1'b0;
        in_ch.write_access    <= 1'b0;
        in_ch.path_unresolved <= 1'b0;
        in_ch.prior_failed    <= 1'b0;
        in_ch.rule_slot       <= '0;
        in_ch.rule_hash       <= '0;
        in_ch.rule_access     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_ENFORCING;
        cfg_ch.data           <= '0;
        model_enforcing  = 1'b0;
        model_rule_count = '0;
        model_hash       = FNV_BASIS;
        model_len        = 0;
        for (int i = 0; i < RULE_ENTRIES; i++)
        begin
            model_rule_hash[i] = '0;
            model_rule_mask[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            verdict_tally[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_register_map();
        test_decisions();
        test_overlong_path();
        test_random_traffic();
        drain_results(SETTLE_CYCLES);

        $display("%0d requests sent, %0d decisions: %0d audited, %0d denied, %0d silent, %0d prior",
                 requests_sent, verdict_tally[0] + verdict_tally[1] + verdict_tally[2]
                 + verdict_tally[3], verdict_tally[DEC_ALLOW_AUDIT], verdict_tally[DEC_DENY],
                 verdict_tally[DEC_ALLOW_SILENT], verdict_tally[DEC_PRIOR_FAIL]);
        $display("%0d decisions hit a rule slot; rule counts 0 to 31 and overlong paths exercised",
                 match_tally);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
